>>> design/dfpgs_pkg.sv
// shared types, codes and defaults for the diagonal five-point grid smoother
package dfpgs_pkg;

    // default sizes
    localparam int DEF_MAX_ROWS    = 512;
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_SAMPLE_BITS = 24;

    // width used for size compares (covers the largest row or column count)
    localparam int DIM_BITS = 13;

    // command codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SMOOTH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PASS_COUNT  = 2'd0;
    localparam logic [1:0] REG_ROWS_IN_USE = 2'd1;
    localparam logic [1:0] REG_COLS_IN_USE = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;

    // configuration reset values
    localparam logic [7:0] PASS_COUNT_RST  = 8'd1;
    localparam logic [9:0] ROWS_IN_USE_RST = 10'd401;
    localparam logic [8:0] COLS_IN_USE_RST = 9'd200;

    typedef struct packed {
        logic [1:0]  operation;
        logic [8:0]  row;
        logic [7:0]  col;
        logic [23:0] sample_in;
    } cmd_t;

    typedef struct packed {
        logic [23:0] sample_out;
        logic        passes_done;
        logic        out_of_range;
    } result_t;

    // control into the stencil datapath, aligned with the memory read data
    typedef struct packed {
        logic valid;
        logic store;
    } stencil_ctl_t;

    // status back from the stencil datapath
    typedef struct packed {
        logic busy;
        logic wb_valid;
    } stencil_stat_t;

endpackage

>>> design/dfpgs_grid_mem.sv
// grid sample memory: one write port, two registered read ports
module dfpgs_grid_mem #(
    parameter int MAX_ROWS    = dfpgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = dfpgs_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = dfpgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_ROWS)-1:0]  wr_row,
    input  logic [$clog2(MAX_COLS)-1:0]  wr_col,
    input  logic [SAMPLE_BITS-1:0]       wr_data,
    input  logic                         rd_a_en,
    input  logic [$clog2(MAX_ROWS)-1:0]  rd_a_row,
    input  logic [$clog2(MAX_COLS)-1:0]  rd_a_col,
    output logic [SAMPLE_BITS-1:0]       rd_a_data,
    input  logic                         rd_b_en,
    input  logic [$clog2(MAX_ROWS)-1:0]  rd_b_row,
    input  logic [$clog2(MAX_COLS)-1:0]  rd_b_col,
    output logic [SAMPLE_BITS-1:0]       rd_b_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] COLS_W = AW'(MAX_COLS);

    logic [SAMPLE_BITS-1:0] mem_array [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_a_data_reg;
    logic [SAMPLE_BITS-1:0] rd_b_data_reg;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_a_addr;
    logic [AW-1:0]          rd_b_addr;

    // row-major layout
    assign wr_addr   = AW'(AW'(wr_row) * COLS_W + AW'(wr_col));
    assign rd_a_addr = AW'(AW'(rd_a_row) * COLS_W + AW'(rd_a_col));
    assign rd_b_addr = AW'(AW'(rd_b_row) * COLS_W + AW'(rd_b_col));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data_reg <= mem_array[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data_reg <= mem_array[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

>>> design/dfpgs_line_buf.sv
// line buffer holding the previous pass values of the row above
module dfpgs_line_buf #(
    parameter int MAX_COLS    = dfpgs_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = dfpgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]  wr_addr,
    input  logic [SAMPLE_BITS-1:0]       wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]  rd_addr,
    output logic [SAMPLE_BITS-1:0]       rd_data
);

    logic [SAMPLE_BITS-1:0] line_array [MAX_COLS];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/dfpgs_stencil.sv
// stencil datapath: 3x3 window, five-term sum, rounded divide by five
module dfpgs_stencil #(
    parameter int SAMPLE_BITS = dfpgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dfpgs_pkg::stencil_ctl_t  ctl,
    input  logic [SAMPLE_BITS-1:0]   top_data,
    input  logic [SAMPLE_BITS-1:0]   mid_data,
    input  logic [SAMPLE_BITS-1:0]   bot_data,
    output logic [SAMPLE_BITS-1:0]   wb_data,
    output dfpgs_pkg::stencil_stat_t stat
);

    // sum width, product width and reciprocal of five
    localparam int SW = SAMPLE_BITS + 3;
    localparam int PW = 2 * SW - 2;
    localparam logic [SW-3:0] RECIP = (SW-2)'((64'd1 << SW) / 64'd5);

    logic [SAMPLE_BITS-1:0] top_p1_reg;
    logic [SAMPLE_BITS-1:0] top_p2_reg;
    logic [SAMPLE_BITS-1:0] mid_p1_reg;
    logic [SAMPLE_BITS-1:0] bot_p1_reg;
    logic [SAMPLE_BITS-1:0] bot_p2_reg;

    logic [SW-1:0] n_next;
    logic [SW-1:0] n_a_reg;
    logic [SW-1:0] n_b_reg;
    logic [PW-1:0] prod_b_reg;
    logic          store_a_reg;
    logic          store_b_reg;

    logic [SW-3:0] q0;
    logic [SW-1:0] five_q;
    logic [SW-1:0] rem;
    logic [SW-3:0] quot;

    // window shift along the row
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            top_p1_reg <= top_data;
            top_p2_reg <= top_p1_reg;
            mid_p1_reg <= mid_data;
            bot_p1_reg <= bot_data;
            bot_p2_reg <= bot_p1_reg;
        end
    end

    // center plus four diagonals, plus two for round to nearest
    assign n_next = SW'(mid_p1_reg) + SW'(top_p2_reg) + SW'(top_data)
                  + SW'(bot_p2_reg) + SW'(bot_data) + SW'(2);

    always_ff @(posedge clk)
    begin
        n_a_reg    <= n_next;
        n_b_reg    <= n_a_reg;
        prod_b_reg <= PW'(n_a_reg) * PW'(RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_a_reg <= 1'b0;
            store_b_reg <= 1'b0;
        end
        else
        begin
            store_a_reg <= ctl.store;
            store_b_reg <= store_a_reg;
        end
    end

    // estimate is low by at most one, fix with a single compare
    assign q0     = prod_b_reg[PW-1:SW];
    assign five_q = {q0, 2'b00} + SW'(q0);
    assign rem    = n_b_reg - five_q;
    assign quot   = (rem >= SW'(5)) ? q0 + (SW-2)'(1) : q0;

    assign wb_data       = SAMPLE_BITS'(quot);
    assign stat.wb_valid = store_b_reg;
    assign stat.busy     = store_a_reg | store_b_reg;

endmodule

>>> design/diagonal_five_point_grid_smoother.sv
// top level of the diagonal five-point grid smoother
//
// channel   direction  handshake                       payload
// -------   ---------  ------------------------------  ----------------------------
// command   in         start && !busy                  cmd (operation/row/col/sample)
// result    out        result_valid, one-cycle strobe  result (sample/done/range flag)
// config    in         cfg_valid && cfg_ready          cfg_index, cfg_data
//
// write, read and no-op commands take one cycle each; their result strobes the cycle
// after the transaction, and a new command may be taken in that same cycle.
// a smooth command runs P passes on R rows and C columns; each pass sweeps rows 0 to
// R - 2, one column step per cycle (two grid reads plus one line buffer read), then
// drains the divide pipeline before the next pass or the done result.
// reset clears control state and resets configuration only; grid contents are undefined
// until written. the receiver cannot stall results, so nothing here waits on it.
module diagonal_five_point_grid_smoother #(
    parameter int MAX_ROWS    = dfpgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = dfpgs_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = dfpgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  dfpgs_pkg::cmd_t                      cmd,
    output logic                                 busy,
    output logic                                 result_valid,
    output dfpgs_pkg::result_t                   result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dfpgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dfpgs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int DW = dfpgs_pkg::DIM_BITS;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // configuration
    logic [7:0] pass_count_reg;
    logic [9:0] rows_in_use_reg;
    logic [8:0] cols_in_use_reg;
    logic [DW-1:0] eff_rows;
    logic [DW-1:0] eff_cols;

    // sequencer
    logic [1:0]    state_reg,     state_next;
    logic [RW-1:0] row_cnt_reg,   row_cnt_next;
    logic [CW-1:0] col_cnt_reg,   col_cnt_next;
    logic [7:0]    pass_left_reg, pass_left_next;

    // address tracking alongside the datapath
    logic          s1_valid_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s2_row_reg;
    logic [CW-1:0] s2_col_reg;
    logic [RW-1:0] s3_row_reg;
    logic [CW-1:0] s3_col_reg;

    // response
    logic resp_valid_reg, resp_valid_next;
    logic resp_read_reg,  resp_read_next;
    logic resp_done_reg,  resp_done_next;
    logic resp_oor_reg,   resp_oor_next;

    logic accept;
    logic op_write;
    logic op_smooth;
    logic op_read;
    logic in_range;
    logic skip_smooth;
    logic issue;
    logic row_last;
    logic col_last;
    logic drain_empty;
    logic pass_finish;

    // memory and datapath hookup
    logic                   g_wr_en;
    logic [RW-1:0]          g_wr_row;
    logic [CW-1:0]          g_wr_col;
    logic [SAMPLE_BITS-1:0] g_wr_data;
    logic                   g_rd_a_en;
    logic [RW-1:0]          g_rd_a_row;
    logic [CW-1:0]          g_rd_a_col;
    logic [SAMPLE_BITS-1:0] g_rd_a_data;
    logic [SAMPLE_BITS-1:0] g_rd_b_data;
    logic [SAMPLE_BITS-1:0] lb_rd_data;
    logic [SAMPLE_BITS-1:0] wb_data;
    dfpgs_pkg::stencil_ctl_t  st_ctl;
    dfpgs_pkg::stencil_stat_t st_stat;

    // ------------------------------------------------------------------
    // configuration registers, written only while idle
    // ------------------------------------------------------------------
    assign cfg_ready = ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_count_reg  <= dfpgs_pkg::PASS_COUNT_RST;
            rows_in_use_reg <= dfpgs_pkg::ROWS_IN_USE_RST;
            cols_in_use_reg <= dfpgs_pkg::COLS_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dfpgs_pkg::REG_PASS_COUNT:  pass_count_reg  <= cfg_data[7:0];
                dfpgs_pkg::REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[9:0];
                dfpgs_pkg::REG_COLS_IN_USE: cols_in_use_reg <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // sizes in use, clamped to the grid dimensions
    assign eff_rows = (DW'(rows_in_use_reg) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS)
                                                             : DW'(rows_in_use_reg);
    assign eff_cols = (DW'(cols_in_use_reg) > DW'(MAX_COLS)) ? DW'(MAX_COLS)
                                                             : DW'(cols_in_use_reg);

    // ------------------------------------------------------------------
    // command decode
    // ------------------------------------------------------------------
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign op_write  = (cmd.operation == dfpgs_pkg::OP_WRITE);
    assign op_smooth = (cmd.operation == dfpgs_pkg::OP_SMOOTH);
    assign op_read   = (cmd.operation == dfpgs_pkg::OP_READ);
    assign in_range  = (DW'(cmd.row) < eff_rows) && (DW'(cmd.col) < eff_cols);

    // no passes or no interior: nothing to compute
    assign skip_smooth = (pass_count_reg == 8'd0) || (eff_rows < DW'(3))
                      || (eff_cols < DW'(3));

    // ------------------------------------------------------------------
    // pass sequencer
    // sweep row r reads rows r and r+1 of the grid plus the line buffer
    // (old row r-1), and writes back row r; row 0 only primes the buffer
    // ------------------------------------------------------------------
    assign issue       = (state_reg == ST_SWEEP);
    assign row_last    = (DW'(row_cnt_reg) == eff_rows - DW'(2));
    assign col_last    = (DW'(col_cnt_reg) == eff_cols - DW'(1));
    assign drain_empty = !s1_valid_reg && !st_stat.busy;
    assign pass_finish = (state_reg == ST_DRAIN) && drain_empty;

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        pass_left_next = pass_left_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op_smooth && !skip_smooth)
                begin
                    state_next     = ST_SWEEP;
                    row_cnt_next   = '0;
                    col_cnt_next   = '0;
                    pass_left_next = pass_count_reg;
                end
            end
            ST_SWEEP:
            begin
                if (col_last)
                begin
                    col_cnt_next = '0;
                    if (row_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + RW'(1);
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                // write-backs must land before the next pass reads them
                if (drain_empty)
                begin
                    if (pass_left_reg == 8'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next     = ST_SWEEP;
                        row_cnt_next   = '0;
                        pass_left_next = pass_left_reg - 8'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            pass_left_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            pass_left_reg <= pass_left_next;
            s1_valid_reg  <= issue;
        end
    end

    // cell coordinates follow the read data and the divide pipeline
    always_ff @(posedge clk)
    begin
        s1_row_reg <= row_cnt_reg;
        s1_col_reg <= col_cnt_reg;
        s2_row_reg <= s1_row_reg;
        s2_col_reg <= s1_col_reg - CW'(1);
        s3_row_reg <= s2_row_reg;
        s3_col_reg <= s2_col_reg;
    end

    // ------------------------------------------------------------------
    // response strobe
    // ------------------------------------------------------------------
    always_comb
    begin
        resp_valid_next = (accept && !(op_smooth && !skip_smooth))
                       || (pass_finish && pass_left_reg == 8'd1);
        resp_read_next  = accept && op_read && in_range;
        resp_done_next  = (accept && op_smooth && skip_smooth)
                       || (pass_finish && pass_left_reg == 8'd1);
        resp_oor_next   = accept && (op_write || op_read) && !in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
            resp_read_reg  <= 1'b0;
            resp_done_reg  <= 1'b0;
            resp_oor_reg   <= 1'b0;
        end
        else
        begin
            resp_valid_reg <= resp_valid_next;
            resp_read_reg  <= resp_read_next;
            resp_done_reg  <= resp_done_next;
            resp_oor_reg   <= resp_oor_next;
        end
    end

    // read data comes straight from the registered memory output
    always_comb
    begin
        result              = '0;
        result.sample_out   = resp_read_reg ? 24'(g_rd_a_data) : 24'd0;
        result.passes_done  = resp_done_reg;
        result.out_of_range = resp_oor_reg;
    end

    assign result_valid = resp_valid_reg;

    // ------------------------------------------------------------------
    // grid memory: write-back or host write, port a sweep or host read
    // ------------------------------------------------------------------
    assign g_wr_en    = st_stat.wb_valid || (accept && op_write && in_range);
    assign g_wr_row   = st_stat.wb_valid ? s3_row_reg : RW'(cmd.row);
    assign g_wr_col   = st_stat.wb_valid ? s3_col_reg : CW'(cmd.col);
    assign g_wr_data  = st_stat.wb_valid ? wb_data : SAMPLE_BITS'(cmd.sample_in);
    assign g_rd_a_en  = issue || (accept && op_read && in_range);
    assign g_rd_a_row = issue ? row_cnt_reg : RW'(cmd.row);
    assign g_rd_a_col = issue ? col_cnt_reg : CW'(cmd.col);

    dfpgs_grid_mem #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_grid (
        .clk       (clk),
        .wr_en     (g_wr_en),
        .wr_row    (g_wr_row),
        .wr_col    (g_wr_col),
        .wr_data   (g_wr_data),
        .rd_a_en   (g_rd_a_en),
        .rd_a_row  (g_rd_a_row),
        .rd_a_col  (g_rd_a_col),
        .rd_a_data (g_rd_a_data),
        .rd_b_en   (issue),
        .rd_b_row  (row_cnt_reg + RW'(1)),
        .rd_b_col  (col_cnt_reg),
        .rd_b_data (g_rd_b_data)
    );

    // old row r is saved as it is read, to serve as row r-1 on the next sweep
    dfpgs_line_buf #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (g_rd_a_data),
        .rd_en   (issue),
        .rd_addr (col_cnt_reg),
        .rd_data (lb_rd_data)
    );

    // store only interior cells: not row 0, and once the window is full
    assign st_ctl.valid = s1_valid_reg;
    assign st_ctl.store = s1_valid_reg && (s1_row_reg != '0) && (s1_col_reg >= CW'(2));

    dfpgs_stencil #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_stencil (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (st_ctl),
        .top_data (lb_rd_data),
        .mid_data (g_rd_a_data),
        .bot_data (g_rd_b_data),
        .wb_data  (wb_data),
        .stat     (st_stat)
    );

`ifndef NO_ASSERTIONS
    // no write-back may be pending once the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !st_stat.wb_valid)
        else $error("write-back while idle");

    // the last pass drained gives exactly a done result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pass_finish && pass_left_reg == 8'd1) |=> (result_valid && result.passes_done))
        else $error("smooth run finished without done result");

    // every non-smooth command answers on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !op_smooth) |=> (result_valid && !result.passes_done))
        else $error("missing result for write or read");

    // a result never flags both done and out of range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.passes_done && result.out_of_range))
        else $error("conflicting result flags");
`endif

endmodule

>>> verif/diagonal_five_point_grid_smoother_tb.sv
// self-checking testbench for the diagonal five-point grid smoother
`timescale 1ns / 100ps

module diagonal_five_point_grid_smoother_tb;
    import dfpgs_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          RESET_CYCLES   = 7;
    localparam int          GRID_ROWS      = DEF_MAX_ROWS;
    localparam int          GRID_COLS      = DEF_MAX_COLS;
    localparam int          GRID_WORDS     = GRID_ROWS * GRID_COLS;
    localparam int          ITEM_TARGET    = 850;
    localparam int          GAP_MAX        = 10;
    localparam int          END_SETTLE     = 20;
    // longest smooth issued is 255 passes on an area of at most 25 cells
    localparam int unsigned WATCHDOG_LIMIT = 40000;
    localparam int unsigned STENCIL_POINTS = 5;
    localparam logic [23:0] SAMPLE_MAX     = 24'hFFFFFF;

    // codes the package does not name
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // phase flavors
    localparam int unsigned PH_SMOOTH = 0;
    localparam int unsigned PH_THIN   = 1;
    localparam int unsigned PH_WIDE   = 2;

    // shadow copy of the grid and the settings, plus the queue of results still owed
    class grid_shadow;
        bit [23:0]   value_at  [GRID_WORDS];
        bit [23:0]   last_pass [GRID_WORDS];
        bit          written   [GRID_WORDS];
        int unsigned pass_count;
        int unsigned rows_in_use;
        int unsigned cols_in_use;
        result_t     expected_q [$];
        int unsigned errors;

        function new();
            pass_count  = PASS_COUNT_RST;
            rows_in_use = ROWS_IN_USE_RST;
            cols_in_use = COLS_IN_USE_RST;
            errors      = 0;
        endfunction

        function int unsigned eff_rows();
            return (rows_in_use > GRID_ROWS) ? GRID_ROWS : rows_in_use;
        endfunction

        function int unsigned eff_cols();
            return (cols_in_use > GRID_COLS) ? GRID_COLS : cols_in_use;
        endfunction

        function int unsigned addr(int unsigned r, int unsigned c);
            return r * GRID_COLS + c;
        endfunction

        function bit in_range(int unsigned r, int unsigned c);
            return (r < eff_rows()) && (c < eff_cols());
        endfunction

        function void set_reg(logic [1:0] idx, logic [9:0] data);
            case (idx)
                REG_PASS_COUNT:  pass_count  = data[7:0];
                REG_ROWS_IN_USE: rows_in_use = data;
                REG_COLS_IN_USE: cols_in_use = data[8:0];
                default: ;
            endcase
        endfunction

        // one jacobi pass: interior cells take the rounded mean of self and diagonals
        function void run_pass();
            int unsigned nr;
            int unsigned nc;
            int unsigned sum;
            nr = eff_rows();
            nc = eff_cols();
            if (nr < 3 || nc < 3)
                return;
            for (int unsigned r = 0; r < nr; r++)
                for (int unsigned c = 0; c < nc; c++)
                    last_pass[addr(r, c)] = value_at[addr(r, c)];
            for (int unsigned r = 1; r + 1 < nr; r++)
                for (int unsigned c = 1; c + 1 < nc; c++)
                begin
                    sum = last_pass[addr(r, c)]
                        + last_pass[addr(r + 1, c + 1)]
                        + last_pass[addr(r - 1, c - 1)]
                        + last_pass[addr(r + 1, c - 1)]
                        + last_pass[addr(r - 1, c + 1)];
                    value_at[addr(r, c)] = 24'((sum + STENCIL_POINTS / 2) / STENCIL_POINTS);
                end
        endfunction

        function void note_command(cmd_t c);
            result_t     want;
            int unsigned a;
            want = '0;
            a    = addr(c.row, c.col);
            case (c.operation)
                OP_WRITE:
                begin
                    if (!in_range(c.row, c.col))
                        want.out_of_range = 1'b1;
                    else
                    begin
                        value_at[a] = c.sample_in;
                        written[a]  = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (!in_range(c.row, c.col))
                        want.out_of_range = 1'b1;
                    else
                        want.sample_out = value_at[a];
                end
                OP_SMOOTH:
                begin
                    repeat (pass_count) run_pass();
                    want.passes_done = 1'b1;
                end
                default: ;
            endcase
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.sample_out !== want.sample_out)
                report($sformatf("sample_out %h, want %h", got.sample_out, want.sample_out));
            if (got.passes_done !== want.passes_done)
                report($sformatf("passes_done %b, want %b", got.passes_done, want.passes_done));
            if (got.out_of_range !== want.out_of_range)
                report($sformatf("out_of_range %b, want %b", got.out_of_range, want.out_of_range));
        endtask
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    cmd_t                      cmd       = '0;
    logic                      busy;
    logic                      result_valid;
    result_t                   result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    grid_shadow  shadow;
    int unsigned items_sent   = 0;
    int unsigned max_gap      = GAP_MAX;
    int unsigned quiet_cycles = 0;
    bit          cmd_driving  = 1'b0;   // start is being held high by the command driver
    int unsigned written_addrs [$];     // in-range write targets, read back later

    diagonal_five_point_grid_smoother u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // results are one-cycle strobes, taken at the edge closing the cycle
    always @(posedge clk)
    begin
        if (rst_n && result_valid !== 1'b0)
            shadow.check_result(result);
    end

    // count cycles in which no transaction of any kind happens
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("diagonal_five_point_grid_smoother_tb: errors");
        $finish;
    end

    // mostly random samples, with the extremes showing up often
    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return 24'($urandom());
        endcase
    endfunction

    // one command transaction; start stays high when the next one follows with no gap
    task automatic send_cmd(input logic [1:0] op, input int unsigned row,
                            input int unsigned col, input logic [23:0] smp);
        cmd_t        c;
        int unsigned gap;
        c.operation = op;
        c.row       = row[8:0];
        c.col       = col[7:0];
        c.sample_in = smp;
        gap         = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            if (cmd_driving)
            begin
                start       <= 1'b0;
                cmd_driving  = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        cmd_driving  = 1'b1;
        do
            @(posedge clk);
        while (busy);
        // in-range writes are remembered so reads can revisit them later
        if (op == OP_WRITE && shadow.in_range(c.row, c.col))
            written_addrs.push_back(shadow.addr(c.row, c.col));
        shadow.note_command(c);
        items_sent++;
    endtask

    // stop issuing and let every owed result come back
    task automatic wait_for_results();
        if (cmd_driving)
        begin
            start       <= 1'b0;
            cmd_driving  = 1'b0;
        end
        while (shadow.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow.set_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // idle the block, then load all three registers; unused data bits carry noise
    task automatic configure(input int unsigned passes, input int unsigned rows,
                             input int unsigned cols, input bit touch_unused);
        logic [9:0] d;
        wait_for_results();
        if (touch_unused)
            write_reg(REG_UNUSED, 10'($urandom()), 1'b0);
        d = {2'($urandom()), passes[7:0]};
        write_reg(REG_PASS_COUNT, d, 1'b0);
        write_reg(REG_ROWS_IN_USE, rows[9:0], 1'b0);
        d = {1'($urandom()), cols[8:0]};
        write_reg(REG_COLS_IN_USE, d, 1'b1);
    endtask

    // every in-use cell must hold a value before a smooth may read it
    task automatic fill_area();
        int unsigned nr;
        int unsigned nc;
        nr = shadow.eff_rows();
        nc = shadow.eff_cols();
        for (int unsigned r = 0; r < nr; r++)
            for (int unsigned c = 0; c < nc; c++)
                if (!shadow.written[shadow.addr(r, c)] || $urandom_range(0, 3) == 0)
                    send_cmd(OP_WRITE, r, c, pick_sample());
    endtask

    task automatic random_op(input bit smooth_ok);
        int unsigned pick;
        int unsigned nr;
        int unsigned nc;
        int unsigned r;
        int unsigned c;
        int unsigned a;
        bit          empty;
        pick  = $urandom_range(0, 99);
        nr    = shadow.eff_rows();
        nc    = shadow.eff_cols();
        empty = (nr == 0) || (nc == 0);
        r     = empty ? 0 : $urandom_range(0, nr - 1);
        c     = empty ? 0 : $urandom_range(0, nc - 1);
        if (pick < 30 && !empty)
            send_cmd(OP_WRITE, r, c, pick_sample());
        else if (pick < 65 && !empty)
        begin
            // half the reads revisit an earlier write target, in range or not by now
            if ($urandom_range(0, 1) == 0 && written_addrs.size() > 0)
            begin
                a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                send_cmd(OP_READ, a / GRID_COLS, a % GRID_COLS, pick_sample());
            end
            else if (shadow.written[shadow.addr(r, c)])
                send_cmd(OP_READ, r, c, pick_sample());
            else
                send_cmd(OP_WRITE, r, c, pick_sample());
        end
        else if (pick < 77 && smooth_ok)
            send_cmd(OP_SMOOTH, $urandom_range(0, 511), $urandom_range(0, 255), pick_sample());
        else if (pick < 85)
            send_cmd(OP_NONE, $urandom_range(0, 511), $urandom_range(0, 255), pick_sample());
        else
        begin
            // address past the in-use area on at least one axis where that exists
            a = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            if (nr <= 511)
                send_cmd(a[1:0], $urandom_range(nr, 511), $urandom_range(0, 255), pick_sample());
            else if (nc <= 255)
                send_cmd(a[1:0], $urandom_range(0, 511), $urandom_range(nc, 255), pick_sample());
            else
                send_cmd(OP_WRITE, r, c, pick_sample());
        end
    endtask

    // one phase: pick sizes and pass count, prime the area when smooths run, then random traffic
    task automatic run_phase(input int unsigned phase);
        int unsigned flavor;
        int unsigned rows;
        int unsigned cols;
        int unsigned passes;
        int unsigned thin;
        int unsigned n_ops;
        bit          smooth_ok;
        case (phase)
            0:       flavor = PH_WIDE;
            1:       flavor = PH_THIN;
            2:       flavor = PH_WIDE;
            default: flavor = ($urandom_range(0, 9) < 6) ? PH_SMOOTH
                            : ($urandom_range(0, 1) ? PH_THIN : PH_WIDE);
        endcase
        case (flavor)
            PH_SMOOTH:
            begin
                rows = $urandom_range(3, 12);
                cols = $urandom_range(3, 12);
                // long pass runs only on tiny grids to keep the run short
                if (rows * cols <= 25 && $urandom_range(0, 5) == 0)
                    passes = 255;
                else if ($urandom_range(0, 9) == 0)
                    passes = 0;
                else
                    passes = $urandom_range(1, 4);
            end
            PH_THIN:
            begin
                // fewer than three rows or columns: no interior at all
                thin   = (phase == 1) ? 0 : $urandom_range(0, 2);
                passes = $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 0 || phase == 1)
                begin
                    rows = thin;
                    cols = $urandom_range(0, 16);
                end
                else
                begin
                    rows = $urandom_range(0, 16);
                    cols = thin;
                end
            end
            default:
            begin
                // large sizes, up to and beyond the grid limits; only reads, writes and no-ops here
                passes = $urandom_range(0, 255);
                case (phase)
                    0:
                    begin
                        rows = 1023;
                        cols = 511;
                    end
                    2:
                    begin
                        rows = GRID_ROWS;
                        cols = GRID_COLS;
                    end
                    default:
                    begin
                        rows = $urandom_range(400, 1023);
                        cols = $urandom_range(200, 511);
                    end
                endcase
            end
        endcase
        configure(passes, rows, cols, phase == 0);
        smooth_ok = (flavor != PH_WIDE);
        max_gap   = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
        if (smooth_ok)
            fill_area();
        n_ops = $urandom_range(20, 60);
        repeat (n_ops)
        begin
            random_op(smooth_ok);
            if ($urandom_range(0, 39) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        int unsigned phase;
        shadow = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: corners of the in-use area and just past it
        send_cmd(OP_WRITE, 0, 0, SAMPLE_MAX);
        send_cmd(OP_READ, 0, 0, '0);
        send_cmd(OP_WRITE, 400, 199, '0);
        send_cmd(OP_READ, 400, 199, SAMPLE_MAX);
        send_cmd(OP_WRITE, 401, 5, SAMPLE_MAX);
        send_cmd(OP_READ, 3, 200, '0);
        send_cmd(OP_READ, 511, 255, '0);
        // unassigned operation code returns an all-zero result
        send_cmd(OP_NONE, 511, 255, SAMPLE_MAX);

        // smallest grid with an interior, full-scale values on a checkerboard, random ones between
        configure(0, 3, 3, 1'b0);
        for (int unsigned r = 0; r < 3; r++)
            for (int unsigned c = 0; c < 3; c++)
                send_cmd(OP_WRITE, r, c, ((r + c) % 2 == 1) ? SAMPLE_MAX : pick_sample());
        // zero passes still reports done and leaves the grid alone
        send_cmd(OP_SMOOTH, 0, 0, '0);
        send_cmd(OP_READ, 1, 1, '0);
        configure(1, 3, 3, 1'b0);
        send_cmd(OP_SMOOTH, 0, 0, '0);
        send_cmd(OP_READ, 1, 1, '0);
        send_cmd(OP_READ, 0, 0, '0);
        configure(255, 3, 3, 1'b0);
        send_cmd(OP_SMOOTH, 511, 255, SAMPLE_MAX);
        send_cmd(OP_READ, 1, 1, '0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phase);
            phase++;
        end

        wait_for_results();
        repeat (END_SETTLE) @(posedge clk);
        if (shadow.expected_q.size() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.expected_q.size()));
        if (shadow.errors == 0)
            $display("diagonal_five_point_grid_smoother_tb: clean");
        else
            $display("diagonal_five_point_grid_smoother_tb: errors");
        $finish;
    end

endmodule
